/* hdl/argb_comp_pkg.sv */
// ----------------------------------------------------------------------------
// ARGB1555 compositor package
// Shared types, register codes, reset values and blend widths.
// ----------------------------------------------------------------------------
`default_nettype none

package argb_comp_pkg;

  localparam int unsigned PixW   = 16;
  localparam int unsigned AlphaW = 8;
  localparam int unsigned LowW   = 7;
  localparam int unsigned OpqW   = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Packed red/blue and green words keep only the low bits that reach the output.
  localparam int unsigned RbW = 29;
  localparam int unsigned GW  = 18;
  localparam int unsigned FracBits = 8;
  localparam int unsigned RoundAdd = 128;

  typedef enum logic [1:0] {
    MODE_COPY  = 2'd0,
    MODE_KEY   = 2'd1,
    MODE_MASK  = 2'd2,
    MODE_BLEND = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE    = 2'd0,
    REG_LOW_THR = 2'd1,
    REG_OPQ_THR = 2'd2
  } reg_idx_e;

  localparam mode_e          ModeRst   = MODE_BLEND;
  localparam logic [LowW-1:0] LowThrRst = 7'd8;
  localparam logic [OpqW-1:0] OpqThrRst = 8'd128;

  typedef struct packed {
    mode_e           mode;
    logic [LowW-1:0] low_thr;
    logic [OpqW-1:0] opq_thr;
  } cfg_t;

  typedef struct packed {
    logic [AlphaW-1:0] alpha;
    logic [PixW-1:0]   dst_pixel;
    logic [PixW-1:0]   src_pixel;
  } in_item_t;

  typedef struct packed {
    logic            write_enable;
    logic [PixW-1:0] out_pixel;
  } out_item_t;

endpackage

`default_nettype wire

/* hdl/argb1555_pixel_compositor.sv */
// ----------------------------------------------------------------------------
// ARGB1555 pixel compositor
// Composites a source pixel onto a destination pixel in one of four modes.
// Items pass through the input and result registers, which set the throughput.
// Throughput is one item per cycle unless m_axis_tready stalls the output.
// Reset clears both stages and loads mode blend, low threshold 8, opaque 128.
// ----------------------------------------------------------------------------
`default_nettype none

module argb1555_pixel_compositor (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [39:0] s_axis_tdata,  // src_pixel[15:0], dst_pixel[31:16], alpha[39:32]
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [15:0] m_axis_tdata, // out_pixel[15:0]
  output logic       m_axis_tuser,  // write_enable[0]
  input  wire        cfg_we_i,
  input  wire [argb_comp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [argb_comp_pkg::CfgDataW-1:0] cfg_data_i
);

  argb_comp_pkg::cfg_t      cfg;
  argb_comp_pkg::in_item_t  in_q;
  argb_comp_pkg::out_item_t res, res_q;
  logic in_vld_q, out_vld_q;
  logic out_ready, in_ready;

  argb_comp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  argb_comp_core u_core (
    .cfg_i  (cfg),
    .item_i (in_q),
    .res_o  (res)
  );

  assign out_ready     = !out_vld_q || m_axis_tready;
  assign in_ready      = !in_vld_q || out_ready;
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_q.src_pixel <= s_axis_tdata[15:0];
      in_q.dst_pixel <= s_axis_tdata[31:16];
      in_q.alpha     <= s_axis_tdata[39:32];
    end
    if (out_ready && in_vld_q) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q.out_pixel;
  assign m_axis_tuser  = res_q.write_enable;

endmodule

`default_nettype wire

/* hdl/argb_comp_cfg.sv */
// ----------------------------------------------------------------------------
// ARGB1555 compositor configuration registers
// Holds mode and thresholds, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module argb_comp_cfg (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire [argb_comp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire [argb_comp_pkg::CfgDataW-1:0]    cfg_data_i,
  output argb_comp_pkg::cfg_t                  cfg_o
);

  argb_comp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (argb_comp_pkg::reg_idx_e'(cfg_idx_i))
        argb_comp_pkg::REG_MODE: begin
          cfg_d.mode = argb_comp_pkg::mode_e'(cfg_data_i[1:0]);
        end
        argb_comp_pkg::REG_LOW_THR: begin
          cfg_d.low_thr = cfg_data_i[argb_comp_pkg::LowW-1:0];
        end
        argb_comp_pkg::REG_OPQ_THR: begin
          cfg_d.opq_thr = cfg_data_i[argb_comp_pkg::OpqW-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode    <= argb_comp_pkg::ModeRst;
      cfg_q.low_thr <= argb_comp_pkg::LowThrRst;
      cfg_q.opq_thr <= argb_comp_pkg::OpqThrRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hdl/argb_comp_core.sv */
// ----------------------------------------------------------------------------
// ARGB1555 compositor datapath
// Mode selection, threshold compares and the rounded alpha blend.
// ----------------------------------------------------------------------------
`default_nettype none

module argb_comp_core (
  input  wire argb_comp_pkg::cfg_t     cfg_i,
  input  wire argb_comp_pkg::in_item_t item_i,
  output argb_comp_pkg::out_item_t     res_o
);

  logic [argb_comp_pkg::PixW-1:0]   s, d;
  logic [argb_comp_pkg::AlphaW-1:0] a;
  logic [argb_comp_pkg::RbW-1:0]    s_rb, d_rb, rb_diff, rb_prod, rb_mix;
  logic [argb_comp_pkg::GW-1:0]     s_g, d_g, g_diff, g_prod, g_mix;
  logic [argb_comp_pkg::AlphaW-1:0] low_ext, blend_max;
  logic                             above_low, blend_ok, opaque;
  logic [argb_comp_pkg::PixW-1:0]   blend_px;

  assign s = item_i.src_pixel;
  assign d = item_i.dst_pixel;
  assign a = item_i.alpha;

  assign s_rb = {8'd0, s[14:10], 11'd0, s[4:0]};
  assign d_rb = {8'd0, d[14:10], 11'd0, d[4:0]};
  assign s_g  = {8'd0, s[9:5], 5'd0};
  assign d_g  = {8'd0, d[9:5], 5'd0};

  assign rb_diff = s_rb - d_rb;
  assign rb_prod = rb_diff * argb_comp_pkg::RbW'(a)
                 + argb_comp_pkg::RbW'(argb_comp_pkg::RoundAdd);
  assign rb_mix  = d_rb + (rb_prod >> argb_comp_pkg::FracBits);

  assign g_diff = s_g - d_g;
  assign g_prod = g_diff * argb_comp_pkg::GW'(a)
                + argb_comp_pkg::GW'(argb_comp_pkg::RoundAdd);
  assign g_mix  = d_g + (g_prod >> argb_comp_pkg::FracBits);

  assign blend_px = {1'b1, rb_mix[20:16], g_mix[9:5], rb_mix[4:0]};

  assign low_ext   = {1'b0, cfg_i.low_thr};
  assign blend_max = 8'd255 - low_ext;
  assign above_low = (a >= low_ext);
  assign blend_ok  = d[15] && (a <= blend_max);
  assign opaque    = (a >= cfg_i.opq_thr);

  always_comb begin
    res_o.out_pixel    = d;
    res_o.write_enable = 1'b0;
    case (cfg_i.mode)
      argb_comp_pkg::MODE_COPY: begin
        res_o.out_pixel    = s;
        res_o.write_enable = 1'b1;
      end
      argb_comp_pkg::MODE_KEY: begin
        if (s[15]) begin
          res_o.out_pixel    = s;
          res_o.write_enable = 1'b1;
        end
      end
      argb_comp_pkg::MODE_MASK: begin
        res_o.out_pixel    = (a[7] ? s : 16'd0) | 16'h8000;
        res_o.write_enable = 1'b1;
      end
      argb_comp_pkg::MODE_BLEND: begin
        if (above_low) begin
          if (blend_ok) begin
            res_o.out_pixel    = blend_px;
            res_o.write_enable = 1'b1;
          end else if (opaque) begin
            res_o.out_pixel    = s | 16'h8000;
            res_o.write_enable = 1'b1;
          end
        end
      end
      default: begin
        res_o.out_pixel    = d;
        res_o.write_enable = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire
